[design/md5_stream_hash_unit_assert.svh]
// ----------------------------------------------------------------------------
// md5_stream_hash_unit_assert
// Assertion macros shared by the MD5 stream hash unit modules.
// ----------------------------------------------------------------------------
`ifndef MD5_STREAM_HASH_UNIT_ASSERT_SVH
`define MD5_STREAM_HASH_UNIT_ASSERT_SVH

// Assertion helpers for the MD5 stream hash unit.
// Both expect signals named clk and rst in the calling scope.

// Consequent must hold in the same cycle as the antecedent.
`define MD5SH_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("md5sh: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MD5SH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("md5sh: next-cycle check failed");

`endif

[design/md5sh_pkg.sv]
// ----------------------------------------------------------------------------
// md5sh_pkg
// Types, constants and round tables shared by the MD5 stream hash unit.
// ----------------------------------------------------------------------------
package md5sh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
  } out_item_t;

  // Controller -> datapath
  typedef struct packed {
    logic       take_byte;
    logic       put_pad;
    logic       put_len;
    logic       load_work;
    logic       do_round;
    logic       add_chain;
    logic       emit;
    logic [5:0] round_idx;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [5:0] pos;
    logic       out_busy;
  } status_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [5:0] LAST_ROUND     = 6'd63;
  localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
  localparam logic [5:0] PAD_LIMIT      = 6'd56;
  localparam logic [3:0] LEN_WORD_LO    = 4'd14;
  localparam logic [3:0] LEN_WORD_HI    = 4'd15;

  // Round group (bits 5:4 of the round index)
  localparam logic [1:0] GRP_F = 2'd0;
  localparam logic [1:0] GRP_G = 2'd1;
  localparam logic [1:0] GRP_H = 2'd2;
  localparam logic [1:0] GRP_I = 2'd3;

  // Message word used by round idx
  function automatic logic [3:0] msg_index(input logic [5:0] idx);
    logic [3:0] i;
    logic [3:0] g;
    i = idx[3:0];
    case (idx[5:4])
      GRP_F:   g = i;
      GRP_G:   g = (i << 2) + i + 4'd1;
      GRP_H:   g = (i << 1) + i + 4'd5;
      GRP_I:   g = (i << 3) - i;
      default: g = i;
    endcase
    return g;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] idx);
    logic [4:0] s;
    case ({idx[5:4], idx[1:0]})
      4'b0000: s = 5'd7;
      4'b0001: s = 5'd12;
      4'b0010: s = 5'd17;
      4'b0011: s = 5'd22;
      4'b0100: s = 5'd5;
      4'b0101: s = 5'd9;
      4'b0110: s = 5'd14;
      4'b0111: s = 5'd20;
      4'b1000: s = 5'd4;
      4'b1001: s = 5'd11;
      4'b1010: s = 5'd16;
      4'b1011: s = 5'd23;
      4'b1100: s = 5'd6;
      4'b1101: s = 5'd10;
      4'b1110: s = 5'd15;
      4'b1111: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'hd76aa478;
    endcase
    return k;
  endfunction

endpackage

[design/md5sh_ctrl.sv]
// ----------------------------------------------------------------------------
// md5sh_ctrl
// Sequencer: input acceptance, padding steps, round counting, digest release.
// ----------------------------------------------------------------------------
`include "md5_stream_hash_unit_assert.svh"

module md5sh_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  md5sh_pkg::in_item_t in_item,
  input  md5sh_pkg::status_t  status,
  output md5sh_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LEN   = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  // Where to go once a compression has been folded into the chain
  typedef enum logic [1:0] {
    AFT_IDLE = 2'd0,
    AFT_PAD  = 2'd1,
    AFT_LEN  = 2'd2,
    AFT_EMIT = 2'd3
  } after_t;

  state_t     state, state_next;
  after_t     after, after_next;
  logic [5:0] round_idx, round_idx_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    after_next     = after;
    round_idx_next = round_idx;
    cmd            = '0;
    cmd.round_idx  = round_idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_byte = in_item.byte_present;
          if (in_item.byte_present && (status.pos == md5sh_pkg::BLOCK_LAST_POS)) begin
            cmd.load_work = 1'b1;
            after_next    = in_item.last ? AFT_PAD : AFT_IDLE;
            state_next    = S_ROUND;
          end else if (in_item.last) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.put_pad = 1'b1;
        if (status.pos >= md5sh_pkg::PAD_LIMIT) begin
          // no room for the length: flush this block first
          cmd.load_work = 1'b1;
          after_next    = AFT_LEN;
          state_next    = S_ROUND;
        end else begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.put_len   = 1'b1;
        cmd.load_work = 1'b1;
        after_next    = AFT_EMIT;
        state_next    = S_ROUND;
      end
      S_ROUND: begin
        cmd.do_round   = 1'b1;
        round_idx_next = round_idx + 6'd1;
        if (round_idx == md5sh_pkg::LAST_ROUND) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        case (after)
          AFT_IDLE: state_next = S_IDLE;
          AFT_PAD:  state_next = S_PAD;
          AFT_LEN:  state_next = S_LEN;
          AFT_EMIT: state_next = S_EMIT;
          default:  state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      after     <= AFT_IDLE;
      round_idx <= '0;
    end else begin
      state     <= state_next;
      after     <= after_next;
      round_idx <= round_idx_next;
    end
  end

  `MD5SH_ASSERT_NEXT(a_last_round_adds, (state == S_ROUND) && (round_idx == md5sh_pkg::LAST_ROUND), state == S_ADD)
  `MD5SH_ASSERT_SAME(a_idx_zero_between_blocks, state != S_ROUND, round_idx == '0)
  `MD5SH_ASSERT_SAME(a_load_starts_rounds, cmd.load_work, state_next == S_ROUND)

endmodule

[design/md5sh_datapath.sv]
// ----------------------------------------------------------------------------
// md5sh_datapath
// Block buffer, byte count, MD5 round unit, chaining words, output register.
// ----------------------------------------------------------------------------
`include "md5_stream_hash_unit_assert.svh"

module md5sh_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  md5sh_pkg::in_item_t  in_item,
  input  md5sh_pkg::cmd_t      cmd,
  output md5sh_pkg::status_t   status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output md5sh_pkg::out_item_t out_item
);

  logic [31:0] chain_words [4];
  logic [31:0] block_words [16];
  logic [31:0] round_words [4];
  logic [31:0] count;

  logic [31:0] f, t, k, m, new_b;
  logic [3:0]  g;
  logic [4:0]  s;
  logic [63:0] rot_dbl;
  logic [5:0]  pos;

  assign pos             = count[5:0];
  assign status.pos      = pos;
  assign status.out_busy = out_valid & out_stall;

  // one MD5 round
  always_comb begin
    case (cmd.round_idx[5:4])
      md5sh_pkg::GRP_F: f = (round_words[1] & round_words[2]) |
                            (~round_words[1] & round_words[3]);
      md5sh_pkg::GRP_G: f = (round_words[3] & round_words[1]) |
                            (~round_words[3] & round_words[2]);
      md5sh_pkg::GRP_H: f = round_words[1] ^ round_words[2] ^ round_words[3];
      md5sh_pkg::GRP_I: f = round_words[2] ^ (round_words[1] | ~round_words[3]);
      default:          f = '0;
    endcase
    g       = md5sh_pkg::msg_index(cmd.round_idx);
    s       = md5sh_pkg::rot_amt(cmd.round_idx);
    k       = md5sh_pkg::round_const(cmd.round_idx);
    m       = block_words[g];
    t       = round_words[0] + f + k + m;
    rot_dbl = {t, t} << s;
    new_b   = round_words[1] + rot_dbl[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_words[0] <= md5sh_pkg::INIT_A;
      chain_words[1] <= md5sh_pkg::INIT_B;
      chain_words[2] <= md5sh_pkg::INIT_C;
      chain_words[3] <= md5sh_pkg::INIT_D;
      for (int i = 0; i < 16; i++) begin
        block_words[i] <= '0;
      end
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // byte lanes ahead of pos are always zero, so a plain write acts as an OR
      if (cmd.take_byte) begin
        block_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= in_item.data_byte;
        count <= count + 32'd1;
      end
      if (cmd.put_pad) begin
        block_words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= md5sh_pkg::PAD_BYTE;
      end
      if (cmd.put_len) begin
        block_words[md5sh_pkg::LEN_WORD_LO] <= {count[28:0], 3'b000};
        block_words[md5sh_pkg::LEN_WORD_HI] <= '0;
      end
      if (cmd.add_chain) begin
        for (int i = 0; i < 4; i++) begin
          chain_words[i] <= chain_words[i] + round_words[i];
        end
        for (int i = 0; i < 16; i++) begin
          block_words[i] <= '0;
        end
      end
      if (cmd.emit) begin
        chain_words[0] <= md5sh_pkg::INIT_A;
        chain_words[1] <= md5sh_pkg::INIT_B;
        chain_words[2] <= md5sh_pkg::INIT_C;
        chain_words[3] <= md5sh_pkg::INIT_D;
        count          <= '0;
        out_valid      <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working words and result payload: no reset
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 4; i++) begin
        round_words[i] <= chain_words[i];
      end
    end else if (cmd.do_round) begin
      round_words[0] <= round_words[3];
      round_words[1] <= new_b;
      round_words[2] <= round_words[1];
      round_words[3] <= round_words[2];
    end
    if (cmd.emit) begin
      out_item.digest_low  <= {chain_words[1], chain_words[0]};
      out_item.digest_high <= {chain_words[3], chain_words[2]};
    end
  end

  `MD5SH_ASSERT_SAME(a_emit_into_free_reg, cmd.emit, !(out_valid && out_stall))
  `MD5SH_ASSERT_NEXT(a_emit_restarts_msg, cmd.emit, out_valid && (count == '0))
  `MD5SH_ASSERT_NEXT(a_take_counts_up, cmd.take_byte, count == $past(count) + 32'd1)

endmodule

[design/md5_stream_hash_unit.sv]
// ----------------------------------------------------------------------------
// md5_stream_hash_unit
// Byte-stream MD5: a byte that completes a 64-byte block stalls input while
// the block is compressed (64 rounds, then the chain add). A last item goes
// through pad, length, rounds and add before its digest is loaded; a pad that
// spills into another block, or a byte that closed a block, adds a compression.
// One MD5 round per cycle in a single shared round unit.
// Reset (rst, synchronous) loads the MD5 initial chain and clears the buffer.
// ----------------------------------------------------------------------------
//
// Structure
//   md5sh_ctrl     - one-hot sequencer: takes items, steps through padding,
//                    counts the 64 rounds, releases the digest.
//   md5sh_datapath - 16-word block buffer, 32-bit byte count, round unit,
//                    chaining words and the output register.
//
// Handshake
//   An item moves on a rising edge with valid high and stall low. Input is
//   taken only while the sequencer is idle. The digest sits in an output
//   register, so later bytes keep flowing while it waits to be taken; a new
//   digest waits only if the previous one is still stalled.
//
// Padding on a last item
//   0x80 goes after the final byte; if it lands at byte 56 or beyond, that
//   block is compressed first. The bit length (mod 2^32) goes in word 14,
//   word 15 stays zero, then the last block is compressed. After the digest
//   is loaded, the chain and count restart for the next message.

module md5_stream_hash_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  md5sh_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output md5sh_pkg::out_item_t out_item
);

  md5sh_pkg::cmd_t    cmd;
  md5sh_pkg::status_t status;

  md5sh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .status   (status),
    .cmd      (cmd)
  );

  md5sh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for md5_stream_hash_unit. Byte items go in through a
// valid/stall port; every digest that comes out is compared field by field
// with an in-bench MD5 predictor. A short table of directed items comes
// first, with known digests typed in. Random messages follow, with lengths
// biased to the padding boundaries. Both ports idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  // Watchdog: cycles with no item moving on either port.
  localparam int QUIET_LIMIT  = 4000;
  // Random stimulus size, in message items (no-op noise not counted).
  localparam int RANDOM_ITEMS = 1800;
  // Long receiver hold-off used to back the block up.
  localparam int HOLDOFF_CYCLES = 400;
  // Drain time after the last digest due, to catch a stray one.
  localparam int DRAIN_CYCLES = 250;

  // MD5 sine-derived round constants, round 0 first.
  localparam logic [0:63][31:0] MD5_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

  // Left-rotate amounts: four per round group, picked by round mod 4.
  localparam logic [0:15][4:0] MD5_ROT = {
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21};

  // Message lengths around the block and padding edges.
  localparam logic [0:10][7:0] BOUNDARY_LEN = {
    8'd0, 8'd55, 8'd56, 8'd57, 8'd63, 8'd64, 8'd65, 8'd119, 8'd120, 8'd127, 8'd128};

  // One row of the directed table. typed = 1 means the digest below is a
  // known answer and is expected in place of the predicted one.
  typedef struct {
    md5sh_pkg::in_item_t  item;
    bit                   typed;
    md5sh_pkg::out_item_t digest;
  } stim_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  md5sh_pkg::in_item_t  in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  md5sh_pkg::out_item_t out_item;

  // Predictor state
  logic [31:0] chain_st [4];
  logic [31:0] blk_st   [16];
  logic [31:0] msg_bytes;

  md5sh_pkg::out_item_t digests_due [$];
  stim_row_t            script_rows [$];

  int send_idle_pct  = 20;
  int recv_idle_pct  = 55;
  bit holdoff_req    = 1'b0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  md5_stream_hash_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // MD5 predictor
  // ---------------------------------------------------------------------------

  // Back to the start of a message: initial chain, empty block, zero count.
  task automatic md5_restart();
    chain_st[0] = 32'h67452301;
    chain_st[1] = 32'hefcdab89;
    chain_st[2] = 32'h98badcfe;
    chain_st[3] = 32'h10325476;
    foreach (blk_st[w]) blk_st[w] = '0;
    msg_bytes = '0;
  endtask

  // 64 rounds over blk_st, folded into the chain; block is cleared after.
  task automatic md5_run_block();
    logic [31:0] a, b, c, d, f, t;
    int          g, sh;
    a = chain_st[0];
    b = chain_st[1];
    c = chain_st[2];
    d = chain_st[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sh = int'(MD5_ROT[(r / 16) * 4 + r % 4]);
      t  = a + f + MD5_K[r] + blk_st[g];
      a  = d;
      d  = c;
      c  = b;
      b  = b + ((t << sh) | (t >> (32 - sh)));
    end
    chain_st[0] = chain_st[0] + a;
    chain_st[1] = chain_st[1] + b;
    chain_st[2] = chain_st[2] + c;
    chain_st[3] = chain_st[3] + d;
    foreach (blk_st[w]) blk_st[w] = '0;
  endtask

  // Takes one accepted item; reports whether it closes a message and, if so,
  // the digest it must produce.
  task automatic md5_take_item(input md5sh_pkg::in_item_t it, output bit done,
                               output md5sh_pkg::out_item_t dig);
    logic [5:0] pos;
    done = 1'b0;
    dig  = '0;
    if (it.byte_present) begin
      pos = msg_bytes[5:0];
      blk_st[pos[5:2]] = blk_st[pos[5:2]] | ({24'h0, it.data_byte} << {pos[1:0], 3'b000});
      msg_bytes = msg_bytes + 1;
      if (pos == 6'd63) md5_run_block();
    end
    if (it.last) begin
      // pad byte, then an extra block if the length word no longer fits
      pos = msg_bytes[5:0];
      blk_st[pos[5:2]] = blk_st[pos[5:2]] | (32'h80 << {pos[1:0], 3'b000});
      if (pos >= 6'd56) md5_run_block();
      blk_st[14] = {msg_bytes[28:0], 3'b000};
      blk_st[15] = '0;
      md5_run_block();
      dig.digest_low  = {chain_st[1], chain_st[0]};
      dig.digest_high = {chain_st[3], chain_st[2]};
      done = 1'b1;
      md5_restart();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count = mismatch_count + 1;
  endtask

  task automatic add_row(input logic [7:0] data, input bit present, input bit last,
                         input bit typed, input logic [63:0] lo, input logic [63:0] hi);
    stim_row_t row;
    row.item.data_byte    = data;
    row.item.byte_present = present;
    row.item.last         = last;
    row.typed             = typed;
    row.digest.digest_low  = lo;
    row.digest.digest_high = hi;
    script_rows.push_back(row);
  endtask

  // Offer one item, hold it while stalled, then log what it should produce.
  // Called at a rising edge; returns at the edge where the item moved.
  task automatic drive_item(input md5sh_pkg::in_item_t it, input bit typed,
                            input md5sh_pkg::out_item_t known);
    bit                   done;
    md5sh_pkg::out_item_t dig;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    md5_take_item(it, done, dig);
    if (done) digests_due.push_back(typed ? known : dig);
  endtask

  // Output side: values read right after the edge are the ones the edge saw.
  initial begin : digest_sink
    int                   holdoff_left;
    bit                   holdoff_taken;
    md5sh_pkg::out_item_t want;
    holdoff_left  = 0;
    holdoff_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (digests_due.size() == 0) begin
          flag_mismatch("digest with none due", out_item.digest_low, '0);
        end else begin
          want = digests_due.pop_front();
          if (out_item.digest_low !== want.digest_low)
            flag_mismatch("digest_low", out_item.digest_low, want.digest_low);
          if (out_item.digest_high !== want.digest_high)
            flag_mismatch("digest_high", out_item.digest_high, want.digest_high);
        end
      end
      // one long hold-off on request, counted here; random stalls otherwise
      if (holdoff_req && !holdoff_taken) begin
        holdoff_left  = HOLDOFF_CYCLES;
        holdoff_taken = 1'b1;
      end
      if (holdoff_left > 0) begin
        out_stall    <= 1'b1;
        holdoff_left  = holdoff_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: nothing moving on either port for too long ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[md5_stream_hash_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    md5sh_pkg::in_item_t  it;
    stim_row_t            row;
    md5sh_pkg::out_item_t none;
    int                   random_count, cur_phase, phase_now, pick, msg_len;
    bit                   split_last;

    none         = '0;
    random_count = 0;
    cur_phase    = 0;
    md5_restart();

    // Directed table. Known answers: empty message, "a", "abc".
    //      data   byte last typed digest_low              digest_high
    add_row(8'h00, 0,   1,   1,    64'h04b2008f_d98c1dd4, 64'h7e42f8ec_980980e9); // empty
    add_row(8'h61, 1,   1,   1,    64'ha8b6f1c0_b975c10c, 64'h61267769_e299c331); // byte+last
    add_row(8'hff, 0,   0,   0,    '0,                    '0);                    // no-op
    add_row(8'h61, 1,   0,   0,    '0,                    '0);
    add_row(8'h62, 1,   0,   0,    '0,                    '0);
    add_row(8'h5a, 0,   0,   0,    '0,                    '0);  // no-op mid message
    add_row(8'h63, 1,   1,   1,    64'hb04fd23c_98500190, 64'h727fe128_7d3f96d6); // "abc"
    add_row(8'h00, 0,   1,   1,    64'h04b2008f_d98c1dd4, 64'h7e42f8ec_980980e9); // empty again
    add_row(8'h00, 1,   0,   0,    '0,                    '0);
    add_row(8'hff, 1,   0,   0,    '0,                    '0);
    add_row(8'h80, 1,   0,   0,    '0,                    '0);
    add_row(8'h7f, 1,   0,   0,    '0,                    '0);
    add_row(8'ha3, 0,   1,   0,    '0,                    '0);  // last alone, junk data
    add_row(8'hff, 1,   1,   0,    '0,                    '0);
    add_row(8'h55, 1,   0,   0,    '0,                    '0);
    add_row(8'haa, 1,   0,   0,    '0,                    '0);
    add_row(8'h01, 1,   0,   0,    '0,                    '0);
    add_row(8'hfe, 0,   0,   0,    '0,                    '0);
    add_row(8'h00, 1,   1,   0,    '0,                    '0);
    add_row(8'hff, 0,   1,   1,    64'h04b2008f_d98c1dd4, 64'h7e42f8ec_980980e9); // empty

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script_rows[n]) begin
      row = script_rows[n];
      drive_item(row.item, row.typed, row.digest);
    end

    // Random messages. Thirds: sender light / receiver heavy idling, then
    // the reverse, then no idling with one long receiver hold-off.
    while (random_count < RANDOM_ITEMS) begin
      phase_now = random_count * 3 / RANDOM_ITEMS;
      if (phase_now != cur_phase) begin
        cur_phase = phase_now;
        if (cur_phase == 1) begin
          send_idle_pct = 55;
          recv_idle_pct = 20;
          // sender pause until every digest due has come out
          in_valid <= 1'b0;
          @(posedge clk);
          while (digests_due.size() != 0) @(posedge clk);
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          holdoff_req   = 1'b1;
        end
      end

      pick = $urandom_range(99);
      if (pick < 12)      msg_len = BOUNDARY_LEN[$urandom_range(10)];
      else if (pick < 88) msg_len = $urandom_range(40);
      else if (pick < 97) msg_len = $urandom_range(130, 41);
      else                msg_len = $urandom_range(300, 131);
      // last either rides on the final byte or comes as an item of its own
      split_last = (msg_len == 0) || ($urandom_range(1) == 1);

      for (int k = 0; k < msg_len; k++) begin
        if ($urandom_range(99) < 4) begin
          it.data_byte    = 8'($urandom_range(255));
          it.byte_present = 1'b0;
          it.last         = 1'b0;
          drive_item(it, 1'b0, none);
        end
        it.data_byte    = 8'($urandom_range(255));
        it.byte_present = 1'b1;
        it.last         = !split_last && (k == msg_len - 1);
        drive_item(it, 1'b0, none);
        random_count = random_count + 1;
      end
      if (split_last) begin
        it.data_byte    = 8'($urandom_range(255));
        it.byte_present = 1'b0;
        it.last         = 1'b1;
        drive_item(it, 1'b0, none);
        random_count = random_count + 1;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (digests_due.size() != 0) @(posedge clk);
    // catch any stray digest after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[md5_stream_hash_unit] OK");
    end else begin
      $display("[md5_stream_hash_unit] ERROR");
    end
    $finish;
  end

endmodule
